// ----- rtl/s7scan_pkg.sv -----
// Shared types, codes and the segment table of the seven-segment scan controller.
`timescale 1ns / 1ps

package s7scan_pkg;

    localparam int SEGMENT_COUNT = 8;
    localparam int CODE_W        = 5;
    localparam int DIGIT_W       = 3;
    localparam int NUMBER_W      = 33;
    localparam int VALUE_W       = 32;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 4;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_UNSIGNED = 2'd1;
    localparam logic [1:0] REQ_SIGNED   = 2'd2;
    localparam logic [1:0] REQ_CHAR     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOT_POSITION = 1'b1;

    localparam logic [CODE_W-1:0] CODE_MINUS = 5'd16;
    localparam logic [CODE_W-1:0] CODE_BLANK = 5'd17;

    localparam logic [SEGMENT_COUNT-1:0] DOT_BIT = 8'h80;

    // One write into the character store.
    typedef struct packed {
        logic               en;
        logic [DIGIT_W-1:0] idx;
        logic [CODE_W-1:0]  code;
    } store_wr_t;

    // Segment pattern of a character code; unused codes light nothing.
    function automatic logic [SEGMENT_COUNT-1:0] seg_pattern(input logic [CODE_W-1:0] code);
        logic [SEGMENT_COUNT-1:0] pat;
        begin
            case (code)
                5'd0:    pat = 8'h3f;
                5'd1:    pat = 8'h06;
                5'd2:    pat = 8'h5b;
                5'd3:    pat = 8'h4f;
                5'd4:    pat = 8'h66;
                5'd5:    pat = 8'h6d;
                5'd6:    pat = 8'h7d;
                5'd7:    pat = 8'h07;
                5'd8:    pat = 8'h7f;
                5'd9:    pat = 8'h6f;
                5'd10:   pat = 8'h77;
                5'd11:   pat = 8'h7c;
                5'd12:   pat = 8'h39;
                5'd13:   pat = 8'h5e;
                5'd14:   pat = 8'h79;
                5'd15:   pat = 8'h71;
                5'd16:   pat = 8'h40;
                5'd17:   pat = 8'h00;
                5'd18:   pat = 8'h01;
                5'd19:   pat = 8'h02;
                5'd20:   pat = 8'h04;
                5'd21:   pat = 8'h08;
                5'd22:   pat = 8'h10;
                5'd23:   pat = 8'h20;
                5'd24:   pat = 8'h40;
                5'd25:   pat = 8'h80;
                default: pat = 8'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

// ----- rtl/seven_segment_scan_controller_top.sv -----
// Top level of the multiplexed seven-segment scan controller.
`timescale 1ns / 1ps

// Usage
// The input stream carries one request per item: tuser holds the request kind
// (scan tick, unsigned value write, signed value write, character write) and
// tdata holds the digit range, the number and the character code. Every item
// yields exactly one output item: the digit now driven and its segment pattern.
// A scan tick or a character write passes from the idle state through the emit
// state into the output register, and the input is ready again once that
// register is loaded. A value write runs the shared divide-by-ten unit once per
// digit of its range in the convert state before the emit state; a signed write
// gives the top digit of its range to the sign and converts the rest. The input
// is not ready while a request is in work; one request is handled at a time.
// The output register holds a finished item while the receiver stalls, and a
// new request is accepted meanwhile; its result waits until that register
// frees up. Configuration (digit count, dot position) is to be written through
// the plain write port while the block is idle; the block does not enforce it.
// Reset clears the scan pointer to digit 0, sets the digit count to 8, turns the
// dot off and blanks every digit.
module seven_segment_scan_controller_top #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: lo_digit[2:0], hi_digit[5:3], number[38:6], char_code[43:39], zero[47:44]
    input  logic [47:0]                       s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: digit_select[2:0], segments[10:3], zero[15:11]
    output logic [15:0]                       m_axis_tdata,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [s7scan_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [s7scan_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import s7scan_pkg::*;

    // The pointer must reach every stored digit.
    localparam int PTR_W = (MAX_DIGITS > 8) ? 4 : 3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [CFG_DATA_W-1:0] digit_count_reg, digit_count_next;
    logic [CFG_DATA_W-1:0] dot_pos_reg, dot_pos_next;
    logic [DIGIT_W-1:0]   conv_idx_reg, conv_idx_next;
    logic [DIGIT_W-1:0]   conv_last_reg, conv_last_next;
    logic [VALUE_W-1:0]   quot_reg, quot_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]   out_digit_reg, out_digit_next;
    logic [SEGMENT_COUNT-1:0] out_seg_reg, out_seg_next;

    // Unpacked input fields.
    logic [1:0]           req_type;
    logic [DIGIT_W-1:0]   lo_digit;
    logic [DIGIT_W-1:0]   hi_digit;
    logic [NUMBER_W-1:0]  number;
    logic [CODE_W-1:0]    char_code;
    logic [VALUE_W-1:0]   low_value;
    logic                 negative;

    logic                 accept;
    logic [PTR_W:0]       ptr_inc;
    logic [VALUE_W-1:0]   div_quot;
    logic [3:0]           div_rem;
    logic [SEGMENT_COUNT-1:0] seg_now;
    store_wr_t            store_wr;

    assign req_type    = s_axis_tuser;
    assign lo_digit    = s_axis_tdata[2:0];
    assign hi_digit    = s_axis_tdata[5:3];
    assign number      = s_axis_tdata[38:6];
    assign char_code   = s_axis_tdata[43:39];
    assign low_value   = number[VALUE_W-1:0];
    assign negative    = low_value[VALUE_W-1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_seg_reg, out_digit_reg};

    // The one divider works on the running quotient, a digit per cycle.
    s7scan_div10 u_div10 (
        .dividend  (quot_reg),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    s7scan_char_store #(
        .MAX_DIGITS (MAX_DIGITS),
        .PTR_W      (PTR_W)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (store_wr),
        .rd_ptr       (ptr_reg),
        .dot_digit    (dot_pos_reg),
        .segments     (seg_now)
    );

    // The pointer wraps when it would reach the digit count or the store size.
    assign ptr_inc = (PTR_W+1)'(ptr_reg) + (PTR_W+1)'(1);

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        digit_count_next = digit_count_reg;
        dot_pos_next     = dot_pos_reg;
        conv_idx_next    = conv_idx_reg;
        conv_last_next   = conv_last_reg;
        quot_next        = quot_reg;
        out_valid_next   = out_valid_reg;
        out_digit_next   = out_digit_reg;
        out_seg_next     = out_seg_reg;
        store_wr         = '0;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIGIT_COUNT:  digit_count_next = cfg_wdata;
                REG_DOT_POSITION: dot_pos_next     = cfg_wdata;
                default:          ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                    case (req_type)
                        REQ_TICK:
                        begin
                            if ((int'(ptr_inc) >= int'(digit_count_reg)) ||
                                (int'(ptr_inc) >= MAX_DIGITS))
                            begin
                                ptr_next = '0;
                            end
                            else
                            begin
                                ptr_next = ptr_inc[PTR_W-1:0];
                            end
                        end
                        REQ_UNSIGNED:
                        begin
                            quot_next      = low_value;
                            conv_idx_next  = lo_digit;
                            conv_last_next = hi_digit;
                            if (lo_digit <= hi_digit)
                            begin
                                state_next = ST_CONV;
                            end
                        end
                        REQ_SIGNED:
                        begin
                            // Sign goes to the top digit, the magnitude below it.
                            store_wr.en    = 1'b1;
                            store_wr.idx   = hi_digit;
                            store_wr.code  = negative ? CODE_MINUS : CODE_BLANK;
                            quot_next      = negative ? (VALUE_W'(0) - low_value) : low_value;
                            conv_idx_next  = lo_digit;
                            conv_last_next = hi_digit - DIGIT_W'(1);
                            if (lo_digit < hi_digit)
                            begin
                                state_next = ST_CONV;
                            end
                        end
                        REQ_CHAR:
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.idx  = lo_digit;
                            store_wr.code = char_code;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONV:
            begin
                store_wr.en   = 1'b1;
                store_wr.idx  = conv_idx_reg;
                store_wr.code = CODE_W'(div_rem);
                quot_next     = div_quot;
                if (conv_idx_reg == conv_last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    conv_idx_next = conv_idx_reg + DIGIT_W'(1);
                end
            end
            ST_EMIT:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = ptr_reg[DIGIT_W-1:0];
                    out_seg_next   = seg_now;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ptr_reg         <= '0;
            digit_count_reg <= CFG_DATA_W'(8);
            dot_pos_reg     <= '1;
            out_valid_reg   <= 1'b0;
            quot_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            digit_count_reg <= digit_count_next;
            dot_pos_reg     <= dot_pos_next;
            out_valid_reg   <= out_valid_next;
            quot_reg        <= quot_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        conv_idx_reg  <= conv_idx_next;
        conv_last_reg <= conv_last_next;
        out_digit_reg <= out_digit_next;
        out_seg_reg   <= out_seg_next;
    end

endmodule

// ----- rtl/s7scan_div10.sv -----
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder by back-subtract.
`timescale 1ns / 1ps

module s7scan_div10 (
    input  logic [s7scan_pkg::VALUE_W-1:0] dividend,
    output logic [s7scan_pkg::VALUE_W-1:0] quotient,
    output logic [3:0]                     remainder
);
    import s7scan_pkg::*;

    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0]   times_ten;
    logic [VALUE_W-1:0]   diff;

    // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
    assign product   = (2*VALUE_W)'(dividend) * (2*VALUE_W)'(RECIP_10);
    assign quotient  = VALUE_W'(product[2*VALUE_W-1:35]);
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign diff      = dividend - times_ten;
    assign remainder = diff[3:0];

endmodule

// ----- rtl/s7scan_char_store.sv -----
// Character store with reset to blank, one write port and the segment lookup of the scanned digit.
`timescale 1ns / 1ps

module s7scan_char_store #(
    parameter int MAX_DIGITS = 8,
    parameter int PTR_W      = 3
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  s7scan_pkg::store_wr_t                  wr,
    input  logic [PTR_W-1:0]                       rd_ptr,
    input  logic [s7scan_pkg::CFG_DATA_W-1:0]      dot_digit,
    output logic [s7scan_pkg::SEGMENT_COUNT-1:0]   segments
);
    import s7scan_pkg::*;

    logic [CODE_W-1:0] mem_reg [MAX_DIGITS];
    logic [CODE_W-1:0] rd_code;
    logic              dot_hit;

    // Writes to digits past the end of the store fall through the loop unmatched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_DIGITS; e++)
            begin
                mem_reg[e] <= CODE_BLANK;
            end
        end
        else
        begin
            for (int e = 0; e < MAX_DIGITS; e++)
            begin
                if (wr.en && (int'(wr.idx) == e))
                begin
                    mem_reg[e] <= wr.code;
                end
            end
        end
    end

    always_comb
    begin
        rd_code = CODE_BLANK;
        for (int e = 0; e < MAX_DIGITS; e++)
        begin
            if (int'(rd_ptr) == e)
            begin
                rd_code = mem_reg[e];
            end
        end
    end

    // A negative dot position never matches a digit.
    assign dot_hit  = !dot_digit[CFG_DATA_W-1] &&
                      (int'(dot_digit[CFG_DATA_W-2:0]) == int'(rd_ptr));
    assign segments = seg_pattern(rd_code) | (dot_hit ? DOT_BIT : '0);

endmodule

// ----- rtl/s7scan_checker.sv -----
// Port-level checks of the scan controller and their attachment to the top level.
`timescale 1ns / 1ps

module s7scan_checker #(
    parameter int MAX_DIGITS = 8
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [15:0]                       m_axis_tdata
);
    import s7scan_pkg::*;

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

    // The input is not ready in the cycle after the block takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

    // The driven digit always lies inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[2:0]) < MAX_DIGITS))
    else $error("digit select beyond the store");

    // The padding bits above the segment pattern of a result item stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0))
    else $error("padding bits of result tdata not zero");

endmodule

bind seven_segment_scan_controller_top s7scan_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_s7scan_checker (.*);
